### sv/pos_pkg.sv
// Shared types and constants for the polyline offset strip block.
package pos_pkg;

    localparam int CoordW = 32;
    localparam int UnitW  = 16;

    localparam logic [1:0] RegNormalOffset  = 2'd0;
    localparam logic [1:0] RegHalfThickness = 2'd1;
    localparam logic [1:0] RegMinLength     = 2'd2;

    // One segment as handed from the front to the back part.
    typedef struct packed {
        logic signed [CoordW-1:0] x0;
        logic signed [CoordW-1:0] y0;
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
    } seg_t;

endpackage

### sv/pos_front.sv
// Front part: holds the previous point and forms segments.
module pos_front
    import pos_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CoordW-1:0] px,
    input  logic signed [CoordW-1:0] py,
    input  logic                     starts_line,
    output logic                     seg_valid,
    input  logic                     seg_ready,
    output seg_t                     seg
);

    logic signed [CoordW-1:0] last_x_reg, last_y_reg;
    logic                     have_last_reg;
    logic                     full_reg;
    logic                     full_next;
    seg_t                     seg_reg;
    logic                     acc;
    logic                     seg_fire;

    assign in_ready  = !full_reg || seg_ready;
    assign acc       = in_valid && in_ready;
    assign seg_valid = full_reg;
    assign seg       = seg_reg;

    // a point that closes a segment refills the slot as the old one leaves
    assign seg_fire  = acc && !starts_line && have_last_reg;
    assign full_next = seg_fire || (full_reg && !seg_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            have_last_reg <= 1'b0;
            full_reg      <= 1'b0;
            seg_reg       <= '0;
        end
        else
        begin
            full_reg <= full_next;
            if (acc)
            begin
                last_x_reg    <= px;
                last_y_reg    <= py;
                have_last_reg <= 1'b1;
            end
            if (seg_fire)
                seg_reg <= '{x0: last_x_reg, y0: last_y_reg, x1: px, y1: py};
        end
    end

endmodule

### sv/pos_back.sv
// Back part: root, divides and corner arithmetic, one segment at a time.
module pos_back
    import pos_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     seg_valid,
    output logic                     seg_ready,
    input  seg_t                     seg,
    input  logic signed [15:0]       normal_offset,
    input  logic [14:0]              half_thickness,
    input  logic [11:0]              min_length,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [8*CoordW-1:0]      out_data
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_ROOT = 9'b000000100,
        S_CHK  = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_UNIT = 9'b000100000,
        S_PROD = 9'b001000000,
        S_SUM  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t                   state_reg;
    seg_t                     s_reg;
    logic signed [32:0]       sx_reg, sy_reg;
    logic                     big_reg;
    logic [63:0]              n_reg, bit_reg, res_reg;
    logic [4:0]               cnt_reg;
    logic [31:0]              len_reg;
    logic [31:0]              remx_reg, remy_reg;
    logic [15:0]              qx_reg, qy_reg;
    logic signed [UnitW-1:0]  ux_reg, uy_reg;
    logic signed [31:0]       pox_reg, poy_reg, phx_reg, phy_reg;
    logic [8*CoordW-1:0]      out_reg;

    logic signed [32:0] ex, ey;
    logic               big;
    logic [31:0]        ax, ay;
    logic [63:0]        n_a, r_a, n_b, r_b, bit_b;
    logic [47:0]        dx, dy;
    logic [32:0]        rx_sh, ry_sh, rx_sub, ry_sub;
    logic               rx_ge, ry_ge;
    logic signed [16:0] nx;
    logic signed [15:0] nxs;
    logic signed [15:0] hth;
    logic signed [31:0] p_ox, p_oy, p_hx, p_hy;
    logic [8*CoordW-1:0] corners;

    // unit component from an unsigned quotient and the sign of the vector part
    function automatic logic signed [15:0] unit_of(input logic [15:0] q,
                                                   input logic neg);
        logic [16:0]        m;
        logic signed [16:0] v;
        m = {1'b0, q};
        if (m > 17'd32768)
            m = 17'd32768;
        v = neg ? -$signed(m) : $signed(m);
        if (v > 17'sd32767)
            v = 17'sd32767;
        return v[15:0];
    endfunction

    // Q.27 to Q.12, round half up
    function automatic logic signed [31:0] rq15(input logic signed [31:0] p);
        logic signed [32:0] q;
        q = 33'(p) + 33'sd16384;
        return 32'(q >>> 15);
    endfunction

    function automatic logic [31:0] sat(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'h7FFFFFFF;
        else if (v < -35'sd2147483648)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

    assign ex  = 33'($signed(seg.x1)) - 33'($signed(seg.x0));
    assign ey  = 33'($signed(seg.y1)) - 33'($signed(seg.y0));
    assign big = (ex > 33'sd2147483647) || (ex < -33'sd2147483647)
              || (ey > 33'sd2147483647) || (ey < -33'sd2147483647);
    assign ax  = sx_reg[32] ? 32'(-sx_reg) : 32'(sx_reg);
    assign ay  = sy_reg[32] ? 32'(-sy_reg) : 32'(sy_reg);

    // two steps of the digit-by-digit root per cycle
    always_comb
    begin
        n_a = n_reg;
        if (n_reg >= res_reg + bit_reg)
        begin
            n_a = n_reg - (res_reg + bit_reg);
            r_a = (res_reg >> 1) + bit_reg;
        end
        else
            r_a = res_reg >> 1;
        bit_b = bit_reg >> 2;
        n_b   = n_a;
        if (n_a >= r_a + bit_b)
        begin
            n_b = n_a - (r_a + bit_b);
            r_b = (r_a >> 1) + bit_b;
        end
        else
            r_b = r_a >> 1;
    end

    // dividends mag*2^15 + len/2; the quotient never exceeds 2^15
    assign dx = {1'b0, ax, 15'd0} + {17'd0, res_reg[31:1]};
    assign dy = {1'b0, ay, 15'd0} + {17'd0, res_reg[31:1]};

    // restoring divide, both components side by side, one bit a cycle
    assign rx_sh  = {remx_reg, qx_reg[15]};
    assign ry_sh  = {remy_reg, qy_reg[15]};
    assign rx_sub = rx_sh - {1'b0, len_reg};
    assign ry_sub = ry_sh - {1'b0, len_reg};
    assign rx_ge  = rx_sh >= {1'b0, len_reg};
    assign ry_ge  = ry_sh >= {1'b0, len_reg};

    assign nx   = -(17'(uy_reg));
    assign nxs  = (nx > 17'sd32767) ? 16'sd32767 : nx[15:0];
    assign hth  = $signed({1'b0, half_thickness});
    assign p_ox = nxs * normal_offset;
    assign p_oy = ux_reg * normal_offset;
    assign p_hx = nxs * hth;
    assign p_hy = ux_reg * hth;

    always_comb
    begin
        corners[31:0]    = sat(35'($signed(s_reg.x0)) + 35'(pox_reg) + 35'(phx_reg));
        corners[63:32]   = sat(35'($signed(s_reg.y0)) + 35'(poy_reg) + 35'(phy_reg));
        corners[95:64]   = sat(35'($signed(s_reg.x1)) + 35'(pox_reg) + 35'(phx_reg));
        corners[127:96]  = sat(35'($signed(s_reg.y1)) + 35'(poy_reg) + 35'(phy_reg));
        corners[159:128] = sat(35'($signed(s_reg.x1)) + 35'(pox_reg) - 35'(phx_reg));
        corners[191:160] = sat(35'($signed(s_reg.y1)) + 35'(poy_reg) - 35'(phy_reg));
        corners[223:192] = sat(35'($signed(s_reg.x0)) + 35'(pox_reg) - 35'(phx_reg));
        corners[255:224] = sat(35'($signed(s_reg.y0)) + 35'(poy_reg) - 35'(phy_reg));
    end

    assign seg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            s_reg     <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            big_reg   <= 1'b0;
            n_reg     <= '0;
            bit_reg   <= '0;
            res_reg   <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            remx_reg  <= '0;
            remy_reg  <= '0;
            qx_reg    <= '0;
            qy_reg    <= '0;
            ux_reg    <= '0;
            uy_reg    <= '0;
            pox_reg   <= '0;
            poy_reg   <= '0;
            phx_reg   <= '0;
            phy_reg   <= '0;
            out_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (seg_valid)
                    begin
                        s_reg   <= seg;
                        big_reg <= big;
                        sx_reg  <= big ? (ex >>> 1) : ex;
                        sy_reg  <= big ? (ey >>> 1) : ey;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    n_reg     <= 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
                    bit_reg   <= 64'h4000000000000000;
                    res_reg   <= '0;
                    cnt_reg   <= 5'd16;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    n_reg   <= n_b;
                    res_reg <= r_b;
                    bit_reg <= bit_reg >> 4;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    // drop zero and short segments
                    if (res_reg[31:0] == '0
                        || (!big_reg && res_reg[31:0] < {20'd0, min_length}))
                        state_reg <= S_IDLE;
                    else
                    begin
                        len_reg   <= res_reg[31:0];
                        remx_reg  <= dx[47:16];
                        remy_reg  <= dy[47:16];
                        qx_reg    <= dx[15:0];
                        qy_reg    <= dy[15:0];
                        cnt_reg   <= 5'd16;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    remx_reg <= rx_ge ? rx_sub[31:0] : rx_sh[31:0];
                    remy_reg <= ry_ge ? ry_sub[31:0] : ry_sh[31:0];
                    qx_reg   <= {qx_reg[14:0], rx_ge};
                    qy_reg   <= {qy_reg[14:0], ry_ge};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                        state_reg <= S_UNIT;
                end
                S_UNIT:
                begin
                    ux_reg    <= unit_of(qx_reg, sx_reg[32]);
                    uy_reg    <= unit_of(qy_reg, sy_reg[32]);
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    pox_reg   <= rq15(p_ox);
                    poy_reg   <= rq15(p_oy);
                    phx_reg   <= rq15(p_hx);
                    phy_reg   <= rq15(p_hy);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    out_reg   <= corners;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### sv/polyline_offset_strip.sv
// Top level of the polyline offset strip block.
// Usage: points enter on the s_axis channel (tdata: point_x, point_y,
// starts_line, lowest bit up). Each point after the first of a line forms
// a segment with the previous point; the block emits the four corners of
// an offset quad on m_axis, or nothing for a line start or a short segment.
// A front stage holds the previous point and queues one segment; the back
// part works one segment at a time: the squares, the root (two steps a
// cycle), one length check, a restoring divide for both components side
// by side, then unit, products and sums. The back part takes a new segment
// only when the last one is skipped or its result has been handed over.
// A skipped segment frees the back part at the length check.
// Reset clears the held point, the queue and the configuration to defaults.
// When the receiver stalls, the result holds; the front can still take
// points until one more segment fills its queue, then it deasserts tready.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
module polyline_offset_strip
    import pos_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,  // point_x, point_y, starts_line, zero pad
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [255:0]  m_axis_tdata,  // start_left_x/y, end_left_x/y,
                                         // end_right_x/y, start_right_x/y
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    logic signed [15:0] normal_offset_reg;
    logic [14:0]        half_thickness_reg;
    logic [11:0]        min_length_reg;
    logic               seg_valid, seg_ready;
    seg_t               seg;

    // hold configuration; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_offset_reg  <= 16'sd2939;
            half_thickness_reg <= 15'd410;
            min_length_reg     <= 12'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegNormalOffset:  normal_offset_reg  <= cfg_data;
                RegHalfThickness: half_thickness_reg <= cfg_data[14:0];
                RegMinLength:     min_length_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    pos_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]),
        .starts_line(s_axis_tdata[64]),
        .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg)
    );

    pos_back u_back (
        .clk(clk), .rst_n(rst_n),
        .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
        .normal_offset(normal_offset_reg), .half_thickness(half_thickness_reg),
        .min_length(min_length_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata)
    );

    // a result is never offered while the back part still takes a request
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && seg_ready)) else $error("result and idle overlap");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");

    // a stalled result keeps its corners
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule
